/* rtl/core/kss_pkg.sv */
// Package for kth_smallest_select: payload structs, queue entry and state types.
// No dependencies; used by every module under rtl/core.
package kss_pkg;

   typedef struct packed {
      logic signed [31:0] element;
      logic [10:0]        rank;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] selected;
      logic               error;
   } rsp_type;

   // front-to-back command: one selection job
   typedef struct packed {
      logic [10:0] rank;
      logic        bad;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_SCAN,
      ST_DECIDE,
      ST_OUT
   } back_state_type;

endpackage

/* rtl/core/kth_smallest_select.sv */
// kth_smallest_select: loads signed 32-bit elements one per beat into a buffer memory;
// the beat with last set also carries a 1-based rank and starts selection. The result is
// the rank-th smallest element (duplicates counted), or error with value 0 when the rank is
// zero or exceeds the count. Elements beyond MAX_ELEMENTS are dropped. Loading accepts one
// beat per cycle. Selection scans the buffer once per candidate through its single read
// port, candidate by candidate until one holds the rank; a bad rank skips the scan. After
// the last beat the input stalls until the result beat is taken.
// Depends on kss_pkg, kss_front, kss_back.
module kth_smallest_select #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kss_pkg::rsp_type rsp_data
);
   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1) > 11 ? $clog2(MAX_ELEMENTS + 1) : 11;

   logic               wr_en, job_push, job_pop, back_busy, q_full_ff;
   logic [CW-1:0]      wr_count, job_count, q_count_ff;
   kss_pkg::job_type   job_data, q_job_ff;
   logic [AW-1:0]      rd_addr;
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] mem [MAX_ELEMENTS];

   // element buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[AW'(wr_count)] <= req_data.element;
      rd_data_ff <= mem[rd_addr];
   end

   // one-entry job queue between front and back
   always_ff @(posedge clock) begin
      if (reset) q_full_ff <= 1'b0;
      else if (job_push) q_full_ff <= 1'b1;
      else if (job_pop)  q_full_ff <= 1'b0;
      if (job_push) begin
         q_job_ff <= job_data; q_count_ff <= job_count;
      end
   end

   kss_front #(.CW(CW)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .max_count(CW'(MAX_ELEMENTS)), .wr_en, .wr_count,
      .job_valid(job_push), .job_full(q_full_ff), .job_data, .job_count, .back_busy);

   kss_back #(.CW(CW), .AW(AW)) u_back (
      .clock, .reset, .job_valid(q_full_ff), .job_data(q_job_ff), .job_count(q_count_ff),
      .job_pop, .rd_addr, .rd_data(rd_data_ff), .rsp_valid, .rsp_stall, .rsp_data);

   // buffer is in use until the job leaves the queue and its result is taken
   logic busy_ff;
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else if (job_pop) busy_ff <= 1'b1;
      else if (rsp_valid && !rsp_stall) busy_ff <= 1'b0;
   end
   assign back_busy = busy_ff;

   assert property (@(posedge clock) disable iff (reset) job_push |-> !q_full_ff)
      else $error("job queue overflow");
   assert property (@(posedge clock) disable iff (reset) wr_en |-> !busy_ff)
      else $error("buffer written during selection");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy_ff)
      else $error("result without job");
endmodule

/* rtl/core/kss_front.sv */
// Front end: writes elements into the buffer, counts them and issues a job per set.
// Depends on kss_pkg.
module kss_front #(
   parameter int CW = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kss_pkg::req_type      req_data,
   input  logic [CW-1:0]         max_count,
   output logic                  wr_en,
   output logic [CW-1:0]         wr_count,
   output logic                  job_valid,
   input  logic                  job_full,
   output kss_pkg::job_type      job_data,
   output logic [CW-1:0]         job_count,
   input  logic                  back_busy
);
   logic [CW-1:0] count_ff, count_in;
   logic          accept;
   logic [CW-1:0] new_count;

   // hold input while the back end still reads the buffer for the last set
   assign req_stall = job_full | back_busy;
   assign accept    = req_valid & ~req_stall;
   assign wr_en     = accept & (count_ff < max_count);
   assign wr_count  = count_ff;
   assign new_count = wr_en ? count_ff + CW'(1) : count_ff;

   assign job_valid     = accept & req_data.last;
   assign job_data.rank = req_data.rank;
   assign job_data.bad  = (req_data.rank == '0) || (CW'(req_data.rank) > new_count);
   assign job_count     = new_count;

   always_comb begin
      count_in = count_ff;
      if (accept) count_in = req_data.last ? '0 : new_count;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end
endmodule

/* rtl/core/kss_back.sv */
// Back end: counting selection over the buffer, one read per cycle, and result register.
// Depends on kss_pkg.
module kss_back #(
   parameter int CW = 11,
   parameter int AW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  kss_pkg::job_type      job_data,
   input  logic [CW-1:0]         job_count,
   output logic                  job_pop,
   output logic [AW-1:0]         rd_addr,
   input  logic signed [31:0]    rd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kss_pkg::rsp_type      rsp_data
);
   kss_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, less_ff, less_in, eq_ff, eq_in;
   logic [CW-1:0] n_ff, n_in;
   logic [10:0]   rank_ff, rank_in;
   logic signed [31:0] cand_ff, cand_in;
   kss_pkg::rsp_type   out_ff, out_in;
   logic [CW:0]   hi;
   logic [CW-1:0] rank_w;

   assign rank_w = CW'(rank_ff);
   assign hi     = {1'b0, less_ff} + {1'b0, eq_ff};

   // next state and datapath
   always_comb begin
      state_in = state_ff; i_in = i_ff; j_in = j_ff; less_in = less_ff; eq_in = eq_ff;
      n_in = n_ff; rank_in = rank_ff; cand_in = cand_ff; out_in = out_ff;
      case (state_ff)
         kss_pkg::ST_IDLE: if (job_valid) begin
            rank_in = job_data.rank; n_in = job_count; i_in = '0;
            if (job_data.bad) begin
               out_in = '{selected: '0, error: 1'b1};
               state_in = kss_pkg::ST_OUT;
            end else state_in = kss_pkg::ST_CAND;
         end
         kss_pkg::ST_CAND: begin
            // candidate read was issued last cycle
            cand_in = rd_data; j_in = '0; less_in = '0; eq_in = '0;
            state_in = kss_pkg::ST_SCAN;
         end
         kss_pkg::ST_SCAN: begin
            // rd_data holds element j-1 from the previous read; j counts issued reads
            if (j_ff != '0) begin
               if (rd_data < cand_ff)       less_in = less_ff + CW'(1);
               else if (rd_data == cand_ff) eq_in   = eq_ff + CW'(1);
            end
            j_in = j_ff + CW'(1);
            if (j_ff == n_ff) state_in = kss_pkg::ST_DECIDE;
         end
         kss_pkg::ST_DECIDE: begin
            if (rank_w > less_ff && {1'b0, rank_w} <= hi) begin
               out_in = '{selected: cand_ff, error: 1'b0};
               state_in = kss_pkg::ST_OUT;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = kss_pkg::ST_CAND;
            end
         end
         kss_pkg::ST_OUT: if (!rsp_stall) state_in = kss_pkg::ST_IDLE;
         default: state_in = kss_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_pop   = (state_ff == kss_pkg::ST_IDLE) & job_valid;
      rsp_valid = (state_ff == kss_pkg::ST_OUT);
      rsp_data  = out_ff;
      rd_addr   = AW'(i_in);
      if (state_ff == kss_pkg::ST_SCAN) rd_addr = AW'(j_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= kss_pkg::ST_IDLE;
      else       state_ff <= state_in;
      i_ff <= i_in; j_ff <= j_in; less_ff <= less_in; eq_ff <= eq_in;
      n_ff <= n_in; rank_ff <= rank_in; cand_ff <= cand_in; out_ff <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.selected == '0)
      else $error("error result with nonzero value");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == kss_pkg::ST_DECIDE |-> {1'b0, less_ff} + {1'b0, eq_ff} <= {1'b0, n_ff})
      else $error("scan counted more than loaded");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == kss_pkg::ST_SCAN |-> j_ff <= n_ff)
      else $error("scan index beyond count");
endmodule

/* bench/kss_checker.sv */
// Checker for kth_smallest_select: watches both channels, keeps its own copy of the
// loaded set, predicts each selection and compares result beats. Depends on kss_pkg.
module kss_checker #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  kss_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  kss_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               results_seen,
   output int               errors_seen
);
   logic signed [31:0] loaded_set [MAX_ELEMENTS];
   int                 loaded_count;
   kss_pkg::rsp_type   expected_q [$];

   // rank-th smallest by counting smaller and equal members for each candidate
   function automatic kss_pkg::rsp_type select_kth(input logic [10:0] want);
      kss_pkg::rsp_type r;
      int less, equal;
      r.selected = '0;
      r.error    = 1'b1;
      if (want == 0 || want > loaded_count) return r;
      for (int i = 0; i < loaded_count; i++) begin
         less  = 0;
         equal = 0;
         for (int j = 0; j < loaded_count; j++) begin
            if (loaded_set[j] < loaded_set[i]) less++;
            else if (loaded_set[j] == loaded_set[i]) equal++;
         end
         if (want > less && want <= less + equal) begin
            r.selected = loaded_set[i];
            r.error    = 1'b0;
            return r;
         end
      end
      return r;
   endfunction

   initial begin
      fail_count   = 0;
      results_seen = 0;
      errors_seen  = 0;
      loaded_count = 0;
   end

   assign pending_count = expected_q.size();

   // input beats: store, and predict on the last one
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (loaded_count < MAX_ELEMENTS) begin
            loaded_set[loaded_count] = req_data.element;
            loaded_count++;
         end
         if (req_data.last) begin
            expected_q.push_back(select_kth(req_data.rank));
            loaded_count = 0;
         end
      end
   end

   // result beats: compare with the oldest prediction
   always @(posedge clock) begin
      kss_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_data.error) errors_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: result beat with none expected: selected=%0d error=%0b",
                     $time, rsp_data.selected, rsp_data.error);
            fail_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (exp_r.selected !== rsp_data.selected) begin
               $display("%0t: selected mismatch: expected %0d, got %0d",
                        $time, exp_r.selected, rsp_data.selected);
               fail_count++;
            end
            if (exp_r.error !== rsp_data.error) begin
               $display("%0t: error flag mismatch: expected %0b, got %0b",
                        $time, exp_r.error, rsp_data.error);
               fail_count++;
            end
         end
      end
   end

endmodule

/* bench/tb_kth_smallest_select.sv */
// Testbench top for kth_smallest_select: clock, reset, stimulus and verdict.
// Depends on kss_pkg, kth_smallest_select and kss_checker.
module tb_kth_smallest_select;
   localparam int MAX_ELEMENTS = 1024;
   localparam int CYCLE_LIMIT  = 6000000;
   localparam int RANDOM_ITEMS = 1200;
   localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_VAL = 32'sh7fff_ffff;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   kss_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   kss_pkg::rsp_type rsp_data;

   int fail_count, pending_count, results_seen, errors_seen;
   int tb_fails = 0;
   int cycles = 0;
   int sets_sent = 0;
   int items_sent = 0;
   bit gaps_on = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   kth_smallest_select #(.MAX_ELEMENTS(MAX_ELEMENTS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   kss_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .results_seen(results_seen), .errors_seen(errors_seen)
   );

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 7) - 4;          // dense, many duplicates
         1: return ($urandom_range(0, 1)) ? MIN_VAL : MAX_VAL;
         2: return $urandom_range(0, 200) - 100;
         default: return $urandom();
      endcase
   endfunction

   // one input beat: optional idle gap, then hold until accepted
   task automatic send_beat(input logic signed [31:0] e, input logic [10:0] r,
                            input logic l);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 9) >= 6)
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data.element = e;
      req_data.rank    = r;
      req_data.last    = l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (l) sets_sent++;
   endtask

   // a set of n random values ending with the given rank
   task automatic send_set(input int n, input logic [10:0] r);
      for (int i = 0; i < n; i++)
         send_beat(pick_value(), (i == n - 1) ? r : 11'($urandom()), i == n - 1);
   endtask

   // receiver: random stall modes, occasional long stalls, one long hold-off
   initial begin
      int mode, hold, mode_left;
      bit pressure_done;
      mode = 0; hold = 0; mode_left = 0; pressure_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         if (!pressure_done && sets_sent >= 15) begin
            pressure_done = 1;
            hold = 800;
         end else if (hold == 0 && mode != 0 && $urandom_range(0, 199) == 0)
            hold = $urandom_range(20, 80);
         if (hold > 0) begin
            hold--;
            rsp_stall = 1'b1;
         end else
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 7) == 0);
               default: rsp_stall = ($urandom_range(0, 1) == 0);
            endcase
      end
   end

   // stimulus
   initial begin
      int n, first_less;
      logic signed [31:0] anchor, v;
      logic [10:0] r;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, errors, duplicates
      send_beat(MIN_VAL, 11'd1, 1'b1);
      send_beat(MAX_VAL, 11'd1, 1'b1);
      send_beat(MAX_VAL, 11'd0, 1'b0);
      send_beat(MIN_VAL, 11'd0, 1'b0);
      send_beat(32'sd0, 11'd0, 1'b0);
      send_beat(-32'sd1, 11'd4, 1'b1);          // largest of four
      send_beat(32'sd7, 11'd0, 1'b0);
      send_beat(32'sd7, 11'd0, 1'b1);           // rank zero
      send_beat(32'sd3, 11'd0, 1'b0);
      send_beat(32'sd3, 11'd3, 1'b1);           // rank beyond count
      send_beat(32'sd5, 11'd0, 1'b0);
      send_beat(32'sd5, 11'd0, 1'b0);
      send_beat(-32'sd2, 11'd0, 1'b0);
      send_beat(32'sd5, 11'd3, 1'b1);           // duplicate at rank
      send_beat(32'sd9, 11'h7ff, 1'b1);         // all rank bits set
      send_beat(MIN_VAL, 11'd1, 1'b0);
      send_beat(MIN_VAL, 11'd2, 1'b1);

      // buffer overflow: the anchor sits first, the dropped tail is the minimum
      gaps_on = 1'b0;
      anchor = 32'sd1000;
      first_less = 0;
      for (int i = 0; i < MAX_ELEMENTS + 6; i++) begin
         if (i == 0) v = anchor;
         else if (i >= MAX_ELEMENTS) v = MIN_VAL;
         else v = $urandom_range(0, 2000);
         if (i > 0 && i < MAX_ELEMENTS && v < anchor) first_less++;
         if (i == MAX_ELEMENTS + 5) send_beat(v, 11'(first_less + 1), 1'b1);
         else send_beat(v, 11'd0, 1'b0);
      end

      // random sets, mostly small, mostly in-range ranks, up to the item budget
      while (items_sent < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         case ($urandom_range(0, 9))
            0: r = 11'd0;
            1: r = 11'($urandom_range(n + 1, 2047));
            2: r = 11'(n);
            default: r = 11'($urandom_range(1, n));
         endcase
         send_set(n, r);
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (pending_count != 0) begin
         $display("%0d predicted results never arrived", pending_count);
         tb_fails++;
      end

      $display("Covered %0d sets: %0d results checked, %0d of them error results,",
               sets_sent, results_seen, errors_seen);
      $display("including a buffer overflow and a long result-side hold-off.");
      if (fail_count == 0 && tb_fails == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
